// File: hdl/msr_pkg.sv
// Shared types and constants for the masked signature resolver.
`default_nettype none

package msr_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int DISP_BYTES    = 4;
   localparam int BYTE_W        = 8;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;
   localparam int OFFSET_W      = 32;
   localparam int ADDR_W        = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW   = 3'd0,
      CSR_PATTERN_HIGH  = 3'd1,
      CSR_BYTE_MASK     = 3'd2,
      CSR_PATTERN_LEN   = 3'd3,
      CSR_RESOLVE_MODE  = 3'd4,
      CSR_DISP_OFFSET   = 3'd5,
      CSR_NEXT_INSN_OFF = 3'd6,
      CSR_SCAN_BASE     = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_RESOLVED   = 2'd0,
      ST_NOT_FOUND  = 2'd1,
      ST_NOT_UNIQUE = 2'd2,
      ST_PAST_END   = 2'd3
   } status_type;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] byte_mask;
      logic [4:0]  pattern_length;
      logic        resolve_mode;
      logic [7:0]  displacement_offset;
      logic [7:0]  next_insn_offset;
      logic [63:0] scan_base;
   } cfg_type;

   // scan outcome handed to the resolve stages at region end
   typedef struct packed {
      logic        found;
      logic        multiple;
      logic [2:0]  held;
      logic [31:0] disp;
   } hit_info_type;

endpackage

`default_nettype wire

// File: hdl/msr_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none

interface msr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msr_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic        unique_res;
   logic [31:0] match_offset;
   logic [63:0] target_address;
   logic [1:0]  status;

   modport source (output valid, output found, output unique_res, output match_offset,
                   output target_address, output status, input ready);
   modport sink (input valid, input found, input unique_res, input match_offset,
                 input target_address, input status, output ready);
endinterface

`default_nettype wire

// File: hdl/masked_signature_resolver.sv
// Top level: configuration registers, tap alignment, byte scan and result resolution.
//
//   channel  | dir | handshake      | payload
//   req_bus  | in  | valid / ready  | data_byte, last_byte
//   rsp_bus  | out | valid / ready  | found, unique_res, match_offset, target_address, status
//   csr_*    | in  | csr_write_en   | csr_index, csr_write_data
//
// One byte per cycle sustained; after the transfer of the region's last byte, the result is
// registered in turn by the input register, window scan, base/offset add and final address add.
// Synchronous reset clears configuration and scan state; no clearing pass is needed.
// A stalled result only blocks the input when a further last byte meets full result
// stages; ordinary bytes keep flowing through the scan.
`default_nettype none

module masked_signature_resolver import msr_pkg::*; #(
   parameter int PATTERN_MAX   = 16,
   parameter int POSITION_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   msr_req_if.sink                     req_bus,
   msr_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int LW = $clog2(PATTERN_MAX + 1);

   cfg_type cfg_ff, cfg_in;

   logic [PATTERN_MAX-1:0][BYTE_W-1:0] tap_pat;
   logic [PATTERN_MAX-1:0]             tap_care;
   logic [PATTERN_MAX-1:0]             tap_disp;
   logic [PATTERN_MAX-1:0][1:0]        tap_dsel;
   logic [2:0]                         hit_held;
   logic [LW-1:0]                      len_m1;
   logic                               len_nz;

   logic                     snap_valid;
   logic                     snap_ready;
   hit_info_type             snap_info;
   logic [POSITION_BITS-1:0] snap_offset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_LOW:   cfg_in.pattern_low         = csr_write_data;
            CSR_PATTERN_HIGH:  cfg_in.pattern_high        = csr_write_data;
            CSR_BYTE_MASK:     cfg_in.byte_mask           = csr_write_data[15:0];
            CSR_PATTERN_LEN:   cfg_in.pattern_length      = csr_write_data[4:0];
            CSR_RESOLVE_MODE:  cfg_in.resolve_mode        = csr_write_data[0];
            CSR_DISP_OFFSET:   cfg_in.displacement_offset = csr_write_data[7:0];
            CSR_NEXT_INSN_OFF: cfg_in.next_insn_offset    = csr_write_data[7:0];
            CSR_SCAN_BASE:     cfg_in.scan_base           = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   msr_align #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_align (
      .clock       (clock),
      .cfg         (cfg_ff),
      .tap_pat_ff  (tap_pat),
      .tap_care_ff (tap_care),
      .tap_disp_ff (tap_disp),
      .tap_dsel_ff (tap_dsel),
      .hit_held_ff (hit_held),
      .len_m1_ff   (len_m1),
      .len_nz_ff   (len_nz)
   );

   msr_scan #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .cfg         (cfg_ff),
      .tap_pat     (tap_pat),
      .tap_care    (tap_care),
      .tap_disp    (tap_disp),
      .tap_dsel    (tap_dsel),
      .hit_held    (hit_held),
      .len_m1      (len_m1),
      .len_nz      (len_nz),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap_info   (snap_info),
      .snap_offset (snap_offset)
   );

   msr_resolve #(
      .POSITION_BITS (POSITION_BITS)
   ) u_resolve (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .snap_valid  (snap_valid),
      .snap_ready  (snap_ready),
      .snap_info   (snap_info),
      .snap_offset (snap_offset),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

// File: hdl/msr_align.sv
// Per-tap pattern, care and displacement selects derived from configuration.
`default_nettype none

module msr_align import msr_pkg::*; #(
   parameter int  PATTERN_MAX = 16,
   localparam int LW          = $clog2(PATTERN_MAX + 1)
) (
   input  wire logic                          clock,
   input  wire cfg_type                       cfg,
   output logic [PATTERN_MAX-1:0][BYTE_W-1:0] tap_pat_ff,
   output logic [PATTERN_MAX-1:0]             tap_care_ff,
   output logic [PATTERN_MAX-1:0]             tap_disp_ff,
   output logic [PATTERN_MAX-1:0][1:0]        tap_dsel_ff,
   output logic [2:0]                         hit_held_ff,
   output logic [LW-1:0]                      len_m1_ff,
   output logic                               len_nz_ff
);

   logic [LW-1:0]                      len;
   logic [6:0]                         len_raw;
   logic [2*64-1:0]                    pat_all;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0] tap_pat_in;
   logic [PATTERN_MAX-1:0]             tap_care_in;
   logic [PATTERN_MAX-1:0]             tap_disp_in;
   logic [PATTERN_MAX-1:0][1:0]        tap_dsel_in;
   logic [2:0]                         hit_held_in;
   logic [7:0]                         held_diff;

   assign len_raw = {2'b00, cfg.pattern_length};
   assign len     = (len_raw > 7'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(cfg.pattern_length);
   assign pat_all = {cfg.pattern_high, cfg.pattern_low};

   // tap j holds the byte that lines up with pattern byte len-1-j
   always_comb begin
      logic [7:0] d;
      logic [7:0] kd;
      logic       in_pat;
      d  = '0;
      kd = '0;
      in_pat = 1'b0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         d      = 8'(len) - 8'(j) - 8'd1;
         in_pat = 8'(j) < 8'(len);
         tap_care_in[j] = in_pat && (d < 8'(PATTERN_BYTES)) && cfg.byte_mask[d[3:0]];
         tap_pat_in[j]  = pat_all[{d[3:0], 3'b000} +: BYTE_W];
         kd             = d - cfg.displacement_offset;
         tap_disp_in[j] = in_pat && (d >= cfg.displacement_offset) &&
                          (kd < 8'(DISP_BYTES));
         tap_dsel_in[j] = kd[1:0];
      end
   end

   // displacement bytes already inside the window at the match byte
   assign held_diff = 8'(len) - cfg.displacement_offset;
   always_comb begin
      if (8'(len) <= cfg.displacement_offset) begin
         hit_held_in = 3'd0;
      end else if (held_diff >= 8'(DISP_BYTES)) begin
         hit_held_in = 3'(DISP_BYTES);
      end else begin
         hit_held_in = held_diff[2:0];
      end
   end

   always_ff @(posedge clock) begin
      tap_pat_ff  <= tap_pat_in;
      tap_care_ff <= tap_care_in;
      tap_disp_ff <= tap_disp_in;
      tap_dsel_ff <= tap_dsel_in;
      hit_held_ff <= hit_held_in;
      len_m1_ff   <= len - LW'(1);
      len_nz_ff   <= len != '0;
   end

endmodule

`default_nettype wire

// File: hdl/msr_scan.sv
// Input register, sliding window compare and first/second hit tracking.
`default_nettype none

module msr_scan import msr_pkg::*; #(
   parameter int  PATTERN_MAX   = 16,
   parameter int  POSITION_BITS = 32,
   localparam int LW            = $clog2(PATTERN_MAX + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   msr_req_if.sink                            req_bus,
   input  wire cfg_type                       cfg,
   input  wire logic [PATTERN_MAX-1:0][BYTE_W-1:0] tap_pat,
   input  wire logic [PATTERN_MAX-1:0]        tap_care,
   input  wire logic [PATTERN_MAX-1:0]        tap_disp,
   input  wire logic [PATTERN_MAX-1:0][1:0]   tap_dsel,
   input  wire logic [2:0]                    hit_held,
   input  wire logic [LW-1:0]                 len_m1,
   input  wire logic                          len_nz,
   output logic                               snap_valid,
   input  wire logic                          snap_ready,
   output hit_info_type                       snap_info,
   output logic [POSITION_BITS-1:0]           snap_offset
);

   localparam int TW = POSITION_BITS + 2;

   logic                     in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]        in_byte_ff, in_byte_in;
   logic                     in_last_ff, in_last_in;
   logic [BYTE_W-1:0]        win_ff [PATTERN_MAX];
   logic [BYTE_W-1:0]        win_in [PATTERN_MAX];
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_upd;
   logic                     first_ff, first_in, first_upd;
   logic                     second_ff, second_in, second_upd;
   logic [POSITION_BITS-1:0] foff_ff, foff_in, foff_upd;
   logic [31:0]              disp_ff, disp_in, disp_upd, disp_hit, disp_str;
   logic [2:0]               held_ff, held_in, held_upd;
   logic                     snap_valid_ff, snap_valid_in;
   hit_info_type             snap_info_ff, snap_info_in;
   logic [POSITION_BITS-1:0] snap_offset_ff, snap_offset_in;

   logic                     scan_go;
   logic                     in_ready;
   logic [PATTERN_MAX-1:0]   mis;
   logic                     hit;
   logic                     stream_cap;
   logic [TW-1:0]            disp_pos;

   assign scan_go  = in_valid_ff && (!in_last_ff || !snap_valid_ff || snap_ready);
   assign in_ready = !in_valid_ff || scan_go;
   assign req_bus.ready = in_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (in_ready) begin
         in_valid_in = req_bus.valid;
         in_byte_in  = req_bus.data_byte;
         in_last_in  = req_bus.last_byte;
      end
   end

   // window after shifting in the current byte
   always_comb begin
      win_in[0] = in_byte_ff;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         win_in[j] = win_ff[j-1];
      end
   end

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         mis[j] = tap_care[j] && (win_in[j] != tap_pat[j]);
      end
   end

   assign hit = !(|mis) && len_nz && (pos_ff >= POSITION_BITS'(len_m1)) && !second_ff;

   // displacement bytes that are already in the window at the first hit
   always_comb begin
      disp_hit = '0;
      for (int k = 0; k < DISP_BYTES; k++) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            if (tap_disp[j] && (tap_dsel[j] == 2'(k))) begin
               disp_hit[BYTE_W*k +: BYTE_W] = disp_hit[BYTE_W*k +: BYTE_W] | win_in[j];
            end
         end
      end
   end

   // later displacement bytes arrive one per transfer
   assign disp_pos   = TW'(foff_ff) + TW'(cfg.displacement_offset) + TW'(held_ff);
   assign stream_cap = first_ff && !held_ff[2] && ({2'b00, pos_ff} == disp_pos);

   always_comb begin
      disp_str = disp_ff;
      disp_str[{held_ff[1:0], 3'b000} +: BYTE_W] = in_byte_ff;
   end

   always_comb begin
      first_upd  = first_ff | hit;
      second_upd = second_ff | (hit & first_ff);
      foff_upd   = foff_ff;
      disp_upd   = disp_ff;
      held_upd   = held_ff;
      if (first_ff) begin
         if (stream_cap) begin
            disp_upd = disp_str;
            held_upd = held_ff + 3'd1;
         end
      end else if (hit) begin
         foff_upd = pos_ff - POSITION_BITS'(len_m1);
         disp_upd = disp_hit;
         held_upd = hit_held;
      end
      pos_upd = (&pos_ff) ? pos_ff : pos_ff + POSITION_BITS'(1);
   end

   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      second_in = second_ff;
      foff_in   = foff_ff;
      disp_in   = disp_ff;
      held_in   = held_ff;
      snap_info_in   = snap_info_ff;
      snap_offset_in = snap_offset_ff;
      snap_valid_in  = snap_valid_ff && !snap_ready;
      if (scan_go) begin
         if (in_last_ff) begin
            // region end: hand off the outcome and start a fresh scan
            snap_valid_in         = 1'b1;
            snap_info_in.found    = first_upd;
            snap_info_in.multiple = second_upd;
            snap_info_in.held     = held_upd;
            snap_info_in.disp     = disp_upd;
            snap_offset_in        = foff_upd;
            pos_in    = '0;
            first_in  = 1'b0;
            second_in = 1'b0;
            foff_in   = '0;
            disp_in   = '0;
            held_in   = '0;
         end else begin
            pos_in    = pos_upd;
            first_in  = first_upd;
            second_in = second_upd;
            foff_in   = foff_upd;
            disp_in   = disp_upd;
            held_in   = held_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pos_ff        <= '0;
         first_ff      <= 1'b0;
         second_ff     <= 1'b0;
         foff_ff       <= '0;
         disp_ff       <= '0;
         held_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         pos_ff        <= pos_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         foff_ff       <= foff_in;
         disp_ff       <= disp_in;
         held_ff       <= held_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      in_last_ff     <= in_last_in;
      snap_info_ff   <= snap_info_in;
      snap_offset_ff <= snap_offset_in;
      if (scan_go) begin
         win_ff <= win_in;
      end
   end

   assign snap_valid  = snap_valid_ff;
   assign snap_info   = snap_info_ff;
   assign snap_offset = snap_offset_ff;

`ifndef ASSERT_OFF
   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> first_ff)
      else $error("second hit recorded without a first hit");

   a_idle_no_disp: assert property (@(posedge clock) disable iff (reset)
      !first_ff |-> (held_ff == 3'd0 && disp_ff == '0 && foff_ff == '0))
      else $error("displacement state set before any hit");

   a_held_limit: assert property (@(posedge clock) disable iff (reset)
      held_ff <= 3'(DISP_BYTES))
      else $error("too many displacement bytes held");

   a_region_clear: assert property (@(posedge clock) disable iff (reset)
      (scan_go && in_last_ff) |=> (pos_ff == '0 && !first_ff && snap_valid_ff))
      else $error("scan state not cleared at region end");
`endif

endmodule

`default_nettype wire

// File: hdl/msr_resolve.sv
// Status decode and address resolution, two register stages to the result channel.
`default_nettype none

module msr_resolve import msr_pkg::*; #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     snap_valid,
   output logic                          snap_ready,
   input  wire hit_info_type             snap_info,
   input  wire logic [POSITION_BITS-1:0] snap_offset,
   msr_rsp_if.source                     rsp_bus
);

   logic                t_valid_ff, t_valid_in;
   logic                t_found_ff;
   logic                t_unique_ff;
   logic [OFFSET_W-1:0] t_off_ff;
   status_type          t_status_ff, t_status_in;
   logic [ADDR_W-1:0]   t_base_ff, t_rel_ff;

   logic                o_valid_ff, o_valid_in;
   logic                o_found_ff;
   logic                o_unique_ff;
   logic [OFFSET_W-1:0] o_off_ff;
   status_type          o_status_ff;
   logic [ADDR_W-1:0]   o_addr_ff, o_addr_in;

   logic o_ready;
   logic t_ready;

   assign o_ready    = !o_valid_ff || rsp_bus.ready;
   assign t_ready    = !t_valid_ff || o_ready;
   assign snap_ready = t_ready;

   always_comb begin
      if (!snap_info.found) begin
         t_status_in = ST_NOT_FOUND;
      end else if (snap_info.multiple) begin
         t_status_in = ST_NOT_UNIQUE;
      end else if (cfg.resolve_mode && !snap_info.held[2]) begin
         t_status_in = ST_PAST_END;
      end else begin
         t_status_in = ST_RESOLVED;
      end
   end

   assign t_valid_in = t_ready ? snap_valid : t_valid_ff;
   assign o_valid_in = o_ready ? t_valid_ff : o_valid_ff;
   assign o_addr_in  = (t_status_ff == ST_RESOLVED) ? t_base_ff + t_rel_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         t_valid_ff <= t_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (t_ready) begin
         t_found_ff  <= snap_info.found;
         t_unique_ff <= snap_info.found && !snap_info.multiple;
         t_off_ff    <= OFFSET_W'(snap_offset);
         t_status_ff <= t_status_in;
         t_base_ff   <= cfg.scan_base + ADDR_W'(snap_offset);
         // data-reference mode adds next-insn offset and sign-extended displacement
         t_rel_ff    <= cfg.resolve_mode ?
                        ADDR_W'(cfg.next_insn_offset) + {{32{snap_info.disp[31]}},
                        snap_info.disp} : '0;
      end
      if (o_ready) begin
         o_found_ff  <= t_found_ff;
         o_unique_ff <= t_unique_ff;
         o_off_ff    <= t_off_ff;
         o_status_ff <= t_status_ff;
         o_addr_ff   <= o_addr_in;
      end
   end

   assign rsp_bus.valid          = o_valid_ff;
   assign rsp_bus.found          = o_found_ff;
   assign rsp_bus.unique_res     = o_unique_ff;
   assign rsp_bus.match_offset   = o_off_ff;
   assign rsp_bus.target_address = o_addr_ff;
   assign rsp_bus.status         = o_status_ff;

`ifndef ASSERT_OFF
   a_resolved_is_unique: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_status_ff == ST_RESOLVED) |-> (o_found_ff && o_unique_ff))
      else $error("resolved result without a unique hit");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && o_status_ff != ST_RESOLVED) |-> (o_addr_ff == '0))
      else $error("failed result carries a nonzero address");

   a_not_found_clean: assert property (@(posedge clock) disable iff (reset)
      (o_valid_ff && !o_found_ff) |-> (o_off_ff == '0 && !o_unique_ff &&
                                       o_status_ff == ST_NOT_FOUND))
      else $error("not-found result has stale fields");
`endif

endmodule

`default_nettype wire
